/* sv/dlt_pkg.sv */
package dlt_pkg;

    // Highest lane count the PHY supports (1, 2 or 4)
    localparam int MAX_LANES = 4;

    // Consecutive unchanged adjust requests before clock recovery gives up
    localparam logic [2:0] CR_STALL_LIMIT = 3'd5;

    // Training pattern codes as written to the sink
    localparam logic [7:0] PAT_NONE = 8'h00;
    localparam logic [7:0] PAT_TPS1 = 8'h01;
    localparam logic [7:0] PAT_TPS2 = 8'h02;
    localparam logic [7:0] PAT_TPS3 = 8'h03;
    localparam logic [7:0] PAT_TPS4 = 8'h07;

    // Enhanced framing flag in the lane count byte
    localparam logic [7:0] ENH_FRAME_BIT = 8'h80;

    // Input event kinds; code 3 is unused and ignored
    typedef enum logic [1:0] {
        FUNC_START    = 2'd0,
        FUNC_STATUS   = 2'd1,
        FUNC_AUX_FAIL = 2'd2
    } t_func;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_SET_LINK = 2'd0,
        KIND_PATTERN  = 2'd1,
        KIND_DONE     = 2'd2,
        KIND_FAIL     = 2'd3
    } t_kind;

    // Training phase
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_CR   = 3'd1,
        PH_EQ   = 3'd2,
        PH_DONE = 3'd3,
        PH_FAIL = 3'd4
    } t_phase;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_START_RATE       = 3'd0,
        CFG_START_LANES      = 3'd1,
        CFG_START_SWING      = 3'd2,
        CFG_START_PREEMPH    = 3'd3,
        CFG_EQ_PATTERN_SEL   = 3'd4,
        CFG_ENHANCED_FRAMING = 3'd5,
        CFG_CR_RETRY_MAX     = 3'd6,
        CFG_EQ_RETRY_MAX     = 3'd7
    } t_cfg_idx;

    // Per-lane 2-bit drive levels, lane 0 lowest
    typedef logic [3:0][1:0] t_drive;

    // One result item
    typedef struct packed {
        t_kind           kind;
        logic [7:0]      pattern;
        logic [7:0]      lane_byte;
        logic [1:0]      rate;
        logic [3:0][5:0] lane_set;
        logic            last;
    } t_result;

    // Results produced by one input item: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    // Map a requested lane count onto 1, 2 or 4, capped by the PHY
    function automatic logic [2:0] norm_lanes(input logic [2:0] n);
        logic [2:0] v;
        begin
            if (n == 3'd0) begin
                v = 3'd1;
            end else if (n >= 3'd3) begin
                v = 3'd4;
            end else begin
                v = n;
            end
            if (int'(v) > MAX_LANES) begin
                v = (MAX_LANES >= 2) ? 3'd2 : 3'd1;
            end
            return v;
        end
    endfunction

    // Pattern code used during equalization
    function automatic logic [7:0] eq_code(input logic [1:0] sel);
        begin
            case (sel)
                2'd1:    return PAT_TPS3;
                2'd2:    return PAT_TPS4;
                default: return PAT_TPS2;
            endcase
        end
    endfunction

    // Training set byte for one lane, with max-level flags
    function automatic logic [5:0] lane_set(input logic [1:0] s, input logic [1:0] p);
        begin
            return {(p == 2'd3), p, (s == 2'd3), s};
        end
    endfunction

    // Check that every active lane reports all bits of mask
    function automatic logic lanes_ok(input logic [15:0] st, input logic [3:0] mask,
                                      input logic [2:0] lanes);
        logic ok;
        begin
            ok = 1'b1;
            for (int i = 0; i < 4; i++) begin
                if ((3'(i) < lanes) && ((st[4*i +: 4] & mask) != mask)) begin
                    ok = 1'b0;
                end
            end
            return ok;
        end
    endfunction

    // Assemble one result item from the link state
    function automatic t_result make_result(input t_kind kind, input logic [7:0] pat,
                                            input logic last, input logic [2:0] lanes,
                                            input logic [1:0] rate, input logic ef,
                                            input t_drive swing, input t_drive preemph);
        t_result r;
        begin
            r.kind       = kind;
            r.pattern    = pat;
            r.lane_byte  = {5'd0, lanes} | (ef ? ENH_FRAME_BIT : 8'h00);
            r.rate       = rate;
            for (int i = 0; i < 4; i++) begin
                r.lane_set[i] = ((kind == KIND_PATTERN) && (3'(i) < lanes)) ?
                                lane_set(swing[i], preemph[i]) : 6'd0;
            end
            r.last       = last;
            return r;
        end
    endfunction

endpackage

/* sv/dp_link_training_sequencer.sv */
// DisplayPort link-training sequencer. Each event item (start, sink status reply,
// aux failure) enters on the s-side stream and is processed in the cycle it is
// accepted; the zero to two result items it causes (set link, training pattern with
// per-lane drive settings, done or fail) go into a four-entry result queue that
// drives the m-side stream. One event item can be taken every cycle as long as
// the queue has room for two results; results leave at one per cycle while the
// m-side is ready, so a run of events that each cause two results is throttled by
// the queue draining. The configuration port is always ready and should only be
// written while no training results are pending.
module dp_link_training_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    // event items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,  // func
    // lane01_status, lane23_status, align_status, adjust01, adjust23
    input  logic [39:0] s_axis_tdata,
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [1:0]  m_axis_tuser,  // kind
    // pattern_byte, lane_count_byte, link rate, lane0_set .. lane3_set, zero pad
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    dlt_pkg::t_push   push;
    dlt_pkg::t_result item;
    logic             space;
    logic             accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = space;
    assign accept        = s_axis_tvalid && space;

    dlt_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_func      (s_axis_tuser),
        .i_status    (s_axis_tdata[15:0]),
        .i_aligned   (s_axis_tdata[16]),
        .i_adjust    (s_axis_tdata[39:24]),
        .o_push      (push)
    );

    dlt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_item  (item)
    );

    // Pack the result item onto the stream
    assign m_axis_tuser = item.kind;
    assign m_axis_tlast = item.last;
    assign m_axis_tdata = {6'd0, item.lane_set[3], item.lane_set[2], item.lane_set[1],
                           item.lane_set[0], item.rate, item.lane_byte, item.pattern};

endmodule

/* sv/dlt_core.sv */
module dlt_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [3:0]       i_cfg_data,
    input  logic             i_accept,
    input  logic [1:0]       i_func,
    input  logic [15:0]      i_status,
    input  logic             i_aligned,
    input  logic [15:0]      i_adjust,
    output dlt_pkg::t_push   o_push
);

    // Configuration registers
    logic [1:0] r_start_rate;
    logic [2:0] r_start_lanes;
    logic [1:0] r_start_swing;
    logic [1:0] r_start_preemph;
    logic [1:0] r_eq_pattern_sel;
    logic       r_enhanced_framing;
    logic [3:0] r_cr_retry_max;
    logic [3:0] r_eq_retry_max;

    // Training state
    dlt_pkg::t_phase r_phase, n_phase;
    logic [1:0]      r_rate, n_rate;
    logic [2:0]      r_lanes, n_lanes;
    dlt_pkg::t_drive r_swing, n_swing;
    dlt_pkg::t_drive r_preemph, n_preemph;
    logic [3:0]      r_retry, n_retry;
    logic [2:0]      r_stall, n_stall;

    // Result selection from the next-state logic
    logic            emit_begin;
    logic            emit_one;
    dlt_pkg::t_kind  one_kind;
    logic [7:0]      one_pat;

    logic            cr_ok;
    logic            eq_ok;
    logic            updated;
    logic            fall;
    dlt_pkg::t_drive adj_swing;
    dlt_pkg::t_drive adj_preemph;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_rate       <= 2'd3;
            r_start_lanes      <= 3'd4;
            r_start_swing      <= 2'd0;
            r_start_preemph    <= 2'd0;
            r_eq_pattern_sel   <= 2'd0;
            r_enhanced_framing <= 1'b1;
            r_cr_retry_max     <= 4'd10;
            r_eq_retry_max     <= 4'd5;
        end else if (i_cfg_we) begin
            case (dlt_pkg::t_cfg_idx'(i_cfg_index))
                dlt_pkg::CFG_START_RATE:       r_start_rate       <= i_cfg_data[1:0];
                dlt_pkg::CFG_START_LANES:      r_start_lanes      <= i_cfg_data[2:0];
                dlt_pkg::CFG_START_SWING:      r_start_swing      <= i_cfg_data[1:0];
                dlt_pkg::CFG_START_PREEMPH:    r_start_preemph    <= i_cfg_data[1:0];
                dlt_pkg::CFG_EQ_PATTERN_SEL:   r_eq_pattern_sel   <= i_cfg_data[1:0];
                dlt_pkg::CFG_ENHANCED_FRAMING: r_enhanced_framing <= i_cfg_data[0];
                dlt_pkg::CFG_CR_RETRY_MAX:     r_cr_retry_max     <= i_cfg_data;
                dlt_pkg::CFG_EQ_RETRY_MAX:     r_eq_retry_max     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Decode status and adjust requests
    always_comb begin
        cr_ok = dlt_pkg::lanes_ok(i_status, 4'h1, r_lanes);
        eq_ok = dlt_pkg::lanes_ok(i_status, 4'h7, r_lanes);
        for (int i = 0; i < 4; i++) begin
            adj_swing[i]   = i_adjust[4*i +: 2];
            adj_preemph[i] = i_adjust[4*i+2 +: 2];
        end
        updated = (adj_swing != r_swing) || (adj_preemph != r_preemph);
    end

    // Next state
    always_comb begin
        n_phase    = r_phase;
        n_rate     = r_rate;
        n_lanes    = r_lanes;
        n_swing    = r_swing;
        n_preemph  = r_preemph;
        n_retry    = r_retry;
        n_stall    = r_stall;
        emit_begin = 1'b0;
        emit_one   = 1'b0;
        one_kind   = dlt_pkg::KIND_PATTERN;
        one_pat    = dlt_pkg::PAT_NONE;
        fall       = 1'b0;

        case (dlt_pkg::t_func'(i_func))
            dlt_pkg::FUNC_START: begin
                n_rate     = r_start_rate;
                n_lanes    = dlt_pkg::norm_lanes(r_start_lanes);
                emit_begin = 1'b1;
            end
            dlt_pkg::FUNC_AUX_FAIL: begin
                if (r_phase == dlt_pkg::PH_CR || r_phase == dlt_pkg::PH_EQ) begin
                    n_phase  = dlt_pkg::PH_FAIL;
                    emit_one = 1'b1;
                    one_kind = dlt_pkg::KIND_FAIL;
                end
            end
            dlt_pkg::FUNC_STATUS: begin
                if (r_phase == dlt_pkg::PH_CR) begin
                    if (cr_ok) begin
                        n_phase  = dlt_pkg::PH_EQ;
                        n_retry  = 4'd0;
                        emit_one = 1'b1;
                        one_pat  = dlt_pkg::eq_code(r_eq_pattern_sel);
                    end else begin
                        n_swing   = adj_swing;
                        n_preemph = adj_preemph;
                        if (r_retry != 4'd15) n_retry = r_retry + 4'd1;
                        if (updated) begin
                            n_stall = 3'd0;
                        end else if (r_stall != 3'd7) begin
                            n_stall = r_stall + 3'd1;
                        end
                        if (n_retry < r_cr_retry_max && n_stall < dlt_pkg::CR_STALL_LIMIT) begin
                            emit_one = 1'b1;
                            one_pat  = dlt_pkg::PAT_TPS1;
                        end else begin
                            fall = 1'b1;
                        end
                    end
                end else if (r_phase == dlt_pkg::PH_EQ) begin
                    if (!cr_ok) begin
                        fall = 1'b1;
                    end else if (i_aligned && eq_ok) begin
                        n_phase  = dlt_pkg::PH_DONE;
                        emit_one = 1'b1;
                        one_kind = dlt_pkg::KIND_DONE;
                    end else begin
                        n_swing   = adj_swing;
                        n_preemph = adj_preemph;
                        if (r_retry != 4'd15) n_retry = r_retry + 4'd1;
                        if (n_retry < r_eq_retry_max) begin
                            emit_one = 1'b1;
                            one_pat  = dlt_pkg::eq_code(r_eq_pattern_sel);
                        end else begin
                            fall = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase

        // Drop the rate first, then halve the lanes, else give up
        if (fall) begin
            if (r_rate != 2'd0) begin
                n_rate     = r_rate - 2'd1;
                emit_begin = 1'b1;
            end else if (r_lanes == 3'd4 || r_lanes == 3'd2) begin
                n_lanes    = r_lanes >> 1;
                n_rate     = r_start_rate;
                emit_begin = 1'b1;
            end else begin
                n_phase  = dlt_pkg::PH_FAIL;
                emit_one = 1'b1;
                one_kind = dlt_pkg::KIND_FAIL;
            end
        end

        // Restart clock recovery from the start drive levels
        if (emit_begin) begin
            for (int i = 0; i < 4; i++) begin
                n_swing[i]   = r_start_swing;
                n_preemph[i] = r_start_preemph;
            end
            n_retry = 4'd0;
            n_stall = 3'd0;
            n_phase = dlt_pkg::PH_CR;
        end
    end

    // Results from the updated link state
    always_comb begin
        o_push.count  = 2'd0;
        o_push.first  = dlt_pkg::make_result(one_kind, one_pat, 1'b1, n_lanes, n_rate,
                                             r_enhanced_framing, n_swing, n_preemph);
        o_push.second = dlt_pkg::make_result(dlt_pkg::KIND_PATTERN, dlt_pkg::PAT_TPS1, 1'b1,
                                             n_lanes, n_rate, r_enhanced_framing,
                                             n_swing, n_preemph);
        if (emit_begin) begin
            o_push.first = dlt_pkg::make_result(dlt_pkg::KIND_SET_LINK, dlt_pkg::PAT_NONE,
                                                1'b0, n_lanes, n_rate, r_enhanced_framing,
                                                n_swing, n_preemph);
        end
        if (i_accept) begin
            if (emit_begin) begin
                o_push.count = 2'd2;
            end else if (emit_one) begin
                o_push.count = 2'd1;
            end
        end
    end

    // Advance state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= dlt_pkg::PH_IDLE;
            r_rate    <= 2'd0;
            r_lanes   <= 3'd0;
            r_swing   <= '0;
            r_preemph <= '0;
            r_retry   <= 4'd0;
            r_stall   <= 3'd0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_rate    <= n_rate;
            r_lanes   <= n_lanes;
            r_swing   <= n_swing;
            r_preemph <= n_preemph;
            r_retry   <= n_retry;
            r_stall   <= n_stall;
        end
    end

    // A start always leaves the block in clock recovery
    a_start_enters_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_func == dlt_pkg::FUNC_START) |=> (r_phase == dlt_pkg::PH_CR))
        else $error("start did not enter clock recovery");

    // A pair of results is always set link followed by TPS1
    a_pair_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |-> (o_push.first.kind == dlt_pkg::KIND_SET_LINK &&
        !o_push.first.last && o_push.second.last &&
        o_push.second.pattern == dlt_pkg::PAT_TPS1))
        else $error("bad result pair");

    // A single result closes its item
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd1) |-> o_push.first.last)
        else $error("single result without last");

endmodule

/* sv/dlt_fifo.sv */
module dlt_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dlt_pkg::t_push   i_push,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output dlt_pkg::t_result o_item
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    dlt_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [AW:0]      r_count, n_count;
    logic             pop;

    // Room for the two results one item may bring
    assign o_space = (r_count <= (AW+1)'(DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;

    // Advance pointers and fill count
    always_comb begin
        n_wr    = r_wr + AW'(i_push.count);
        n_rd    = r_rd + AW'(pop);
        n_count = r_count + (AW+1)'(i_push.count) - (AW+1)'(pop);
    end

    // Store incoming results
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + AW'(1)] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Never overfill
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= (AW+1)'(DEPTH)))
        else $error("result queue overflow");

    // Results only arrive when room was reported
    a_push_with_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_space)
        else $error("push without space");

endmodule
